// ----- hw/rtl/adf_pkg.sv -----
// ----------------------------------------------------------------------------
// adf_pkg
// Shared types and constants of the autoscaling decimal formatter.
// ----------------------------------------------------------------------------
package adf_pkg;

    localparam int IN_W       = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int UNITS_W    = 32;
    localparam int ULEN_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_SET     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNITS_TEXT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNITS_LENGTH = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_MILLI = 8'h6D;
    localparam logic [CHAR_W-1:0] CHAR_KILO  = 8'h6B;
    localparam logic [CHAR_W-1:0] CHAR_MICRO = 8'h75;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_ALIGN,
        ST_DIGIT,
        ST_ZERO,
        ST_PREFIX,
        ST_UNITS
    } adf_state_t;

    function automatic logic [CHAR_W-1:0] prefix_char(input logic unit_set,
                                                      input logic [1:0] group);
        logic [CHAR_W-1:0] c;
        c = CHAR_NONE;
        unique case (group)
            2'd0:    c = unit_set ? CHAR_MICRO : CHAR_MILLI;
            2'd1:    c = unit_set ? CHAR_MILLI : CHAR_NONE;
            2'd2:    c = unit_set ? CHAR_NONE : CHAR_KILO;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/adf_bin2bcd.sv -----
// ----------------------------------------------------------------------------
// adf_bin2bcd
// Bit-serial binary to BCD converter, one input bit per cycle.
// ----------------------------------------------------------------------------
module adf_bin2bcd import adf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IN_W-1:0]  value,
    output logic             done,
    output logic [BCD_W-1:0] bcd
);

    localparam int CNT_W = $clog2(IN_W);

    logic [IN_W-1:0]  bin_reg,  bin_next;
    logic [BCD_W-1:0] bcd_reg,  bcd_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [BCD_W-1:0] adj;

    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            adj[4*k +: 4] = (bcd_reg[4*k +: 4] >= 4'd5) ? bcd_reg[4*k +: 4] + 4'd3
                                                        : bcd_reg[4*k +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[IN_W-1]};
            bin_next = {bin_reg[IN_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(IN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ----- hw/rtl/autoscale_decimal_formatter_unit.sv -----
// ----------------------------------------------------------------------------
// autoscale_decimal_formatter_unit
// Formats a signed reading as ASCII decimal text with an SI prefix and unit.
// ----------------------------------------------------------------------------
// A positive reading goes through bit-serial BCD conversion, then leading-zero
// alignment, then is emitted one character at a time (up to 10 characters).
// A reading of zero or below skips conversion and starts emitting at once.
// One reading is handled at a time; the next word is taken after the last
// character has been loaded into the output register.
// Reset (rst_n, asynchronous, active low) clears FSM, control and config regs.
// ----------------------------------------------------------------------------
module autoscale_decimal_formatter_unit import adf_pkg::*;
#(
    parameter int UNITS_MAX_CHARS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [UNITS_W-1:0]   cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // [31:0] reading (signed)
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CHAR_W-1:0]    m_tdata,   // [7:0] char_code
    output logic                 m_tlast    // last_char
);

    localparam int ULEN_LIM_I = (UNITS_MAX_CHARS < 4) ? UNITS_MAX_CHARS : 4;
    localparam logic [ULEN_W-1:0] ULEN_LIM = ULEN_W'(ULEN_LIM_I);

    adf_state_t state_reg, state_next;

    logic                unit_set_reg;
    logic [UNITS_W-1:0]  units_text_reg;
    logic [ULEN_W-1:0]   units_length_reg;

    logic [BCD_W-1:0]    digits_reg,     digits_next;
    logic [3:0]          shift_cnt_reg,  shift_cnt_next;
    logic [2:0]          intd_reg,       intd_next;
    logic [2:0]          total_reg,      total_next;
    logic                has_point_reg,  has_point_next;
    logic                point_done_reg, point_done_next;
    logic [CHAR_W-1:0]   prefix_reg,     prefix_next;
    logic [2:0]          idx_reg,        idx_next;
    logic [ULEN_W-1:0]   unit_idx_reg,   unit_idx_next;

    logic                out_valid_reg,  out_valid_next;
    logic [CHAR_W-1:0]   out_data_reg,   out_data_next;
    logic                out_last_reg,   out_last_next;

    logic                conv_start;
    logic                conv_done;
    logic [BCD_W-1:0]    conv_bcd;
    logic                load;
    logic [ULEN_W-1:0]   ulen;
    logic [3:0]          d_count;
    logic [1:0]          group;
    logic [3:0]          top_digit;

    adf_bin2bcd u_bin2bcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .value (s_tdata),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_set_reg     <= 1'b0;
            units_text_reg   <= '0;
            units_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UNIT_SET:     unit_set_reg     <= cfg_wdata[0];
                REG_UNITS_TEXT:   units_text_reg   <= cfg_wdata;
                REG_UNITS_LENGTH: units_length_reg <= cfg_wdata[ULEN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign ulen      = (units_length_reg > ULEN_LIM) ? ULEN_LIM : units_length_reg;
    assign load      = !out_valid_reg || m_tready;
    assign d_count   = 4'd10 - shift_cnt_reg;
    assign top_digit = digits_reg[BCD_W-1 -: 4];

    always_comb
    begin
        priority if (d_count <= 4'd3)
        begin
            group = 2'd0;
        end
        else if (d_count <= 4'd6)
        begin
            group = 2'd1;
        end
        else
        begin
            group = 2'd2;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        digits_next     = digits_reg;
        shift_cnt_next  = shift_cnt_reg;
        intd_next       = intd_reg;
        total_next      = total_reg;
        has_point_next  = has_point_reg;
        point_done_next = point_done_reg;
        prefix_next     = prefix_reg;
        idx_next        = idx_reg;
        unit_idx_next   = unit_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        conv_start      = 1'b0;
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if ((s_tdata == '0) || s_tdata[IN_W-1])
                    begin
                        state_next = ST_ZERO;
                    end
                    else
                    begin
                        conv_start = 1'b1;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    digits_next    = conv_bcd;
                    shift_cnt_next = '0;
                    state_next     = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                if (top_digit == 4'd0)
                begin
                    digits_next    = {digits_reg[BCD_W-5:0], 4'd0};
                    shift_cnt_next = shift_cnt_reg + 4'd1;
                end
                else
                begin
                    unique case (group)
                        2'd0:    intd_next = d_count[2:0];
                        2'd1:    intd_next = 3'(d_count - 4'd3);
                        default: intd_next = (d_count == 4'd10) ? 3'd4
                                                                : 3'(d_count - 4'd6);
                    endcase
                    total_next      = (group == 2'd0) ? d_count[2:0] : 3'd4;
                    has_point_next  = (group != 2'd0) && (d_count != 4'd10);
                    point_done_next = 1'b0;
                    prefix_next     = prefix_char(unit_set_reg, group);
                    idx_next        = '0;
                    state_next      = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    if (has_point_reg && !point_done_reg && (idx_reg == intd_reg))
                    begin
                        out_data_next   = CHAR_POINT;
                        point_done_next = 1'b1;
                    end
                    else
                    begin
                        out_data_next = CHAR_ZERO + {4'd0, top_digit};
                        digits_next   = {digits_reg[BCD_W-5:0], 4'd0};
                        idx_next      = idx_reg + 3'd1;
                        if (idx_reg == total_reg - 3'd1)
                        begin
                            priority if (prefix_reg != CHAR_NONE)
                            begin
                                state_next = ST_PREFIX;
                            end
                            else if (ulen == '0)
                            begin
                                out_last_next = 1'b1;
                                state_next    = ST_IDLE;
                            end
                            else
                            begin
                                unit_idx_next = '0;
                                state_next    = ST_UNITS;
                            end
                        end
                    end
                end
            end
            ST_ZERO, ST_PREFIX:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = (state_reg == ST_ZERO) ? CHAR_ZERO : prefix_reg;
                    unit_idx_next  = '0;
                    if (ulen == '0)
                    begin
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_last_next = 1'b0;
                        state_next    = ST_UNITS;
                    end
                end
            end
            ST_UNITS:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = units_text_reg[{unit_idx_reg[1:0], 3'b000} +: CHAR_W];
                    unit_idx_next  = unit_idx_reg + 1'b1;
                    if (unit_idx_reg == ulen - 1'b1)
                    begin
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_last_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            shift_cnt_reg  <= '0;
            idx_reg        <= '0;
            unit_idx_reg   <= '0;
            point_done_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            shift_cnt_reg  <= shift_cnt_next;
            idx_reg        <= idx_next;
            unit_idx_reg   <= unit_idx_next;
            point_done_reg <= point_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg    <= digits_next;
        intd_reg      <= intd_next;
        total_reg     <= total_next;
        has_point_reg <= has_point_next;
        prefix_reg    <= prefix_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the autoscaling decimal formatter. Readings go in
// on the slave stream and each expected text is built by a predictor inside
// a scoreboard, then compared word by word with the characters that come out.
// The run walks through reset defaults, several register settings and four
// handshake mixes, with one long output hold-off and one full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
    import adf_pkg::*;

    localparam int UNITS_CLAMP = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 60;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 13;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_word_t;

    class char_scoreboard;
        text_word_t        expected_text[$];
        logic              unit_set;
        logic [UNITS_W-1:0] units_text;
        logic [ULEN_W-1:0] units_length;
        int                errors;

        function new();
            unit_set     = 1'b0;
            units_text   = '0;
            units_length = '0;
            errors       = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [UNITS_W-1:0] value);
            case (idx)
                REG_UNIT_SET:     unit_set = value[0];
                REG_UNITS_TEXT:   units_text = value;
                REG_UNITS_LENGTH: units_length = value[ULEN_W-1:0];
                default:          ;
            endcase
        endfunction

        function void add_char(logic [CHAR_W-1:0] c);
            expected_text.push_back('{code: c, last: 1'b0});
        endfunction

        function void note_reading(logic [IN_W-1:0] reading);
            logic [3:0]        dig[10];
            int unsigned       rest;
            int unsigned       ndig;
            int unsigned       grp;
            int unsigned       int_digits;
            int unsigned       shown;
            int unsigned       ulen;
            int unsigned       k;
            logic [CHAR_W-1:0] pfx;
            ulen = units_length;
            if (ulen > 4)
                ulen = 4;
            if (ulen > UNITS_CLAMP)
                ulen = UNITS_CLAMP;
            if (reading == '0 || reading[IN_W-1])
            begin
                add_char(CHAR_ZERO);
            end
            else
            begin
                rest = reading;
                ndig = 0;
                while (rest != 0)
                begin
                    dig[ndig] = 4'(rest % 10);
                    rest = rest / 10;
                    ndig++;
                end
                grp = (ndig - 1) / 3;
                if (grp > 2)
                    grp = 2;
                int_digits = ndig - 3 * grp;
                shown = (grp != 0 && int_digits < 4) ? 4 : int_digits;
                for (k = 0; k < shown; k++)
                begin
                    if (k == int_digits)
                        add_char(CHAR_POINT);
                    add_char(CHAR_ZERO + dig[ndig - 1 - k]);
                end
                case (grp)
                    0:       pfx = unit_set ? CHAR_MICRO : CHAR_MILLI;
                    1:       pfx = unit_set ? CHAR_MILLI : CHAR_NONE;
                    default: pfx = unit_set ? CHAR_NONE : CHAR_KILO;
                endcase
                if (pfx != CHAR_NONE)
                    add_char(pfx);
            end
            for (k = 0; k < ulen; k++)
                add_char(units_text[8 * k +: 8]);
            expected_text[expected_text.size() - 1].last = 1'b1;
        endfunction

        function void check_char(logic [CHAR_W-1:0] code, logic last);
            text_word_t want;
            if (expected_text.size() == 0)
            begin
                $error("char_code: expected none, actual %h (last_char %b)", code, last);
                errors++;
                return;
            end
            want = expected_text.pop_front();
            if (code !== want.code)
            begin
                $error("char_code: expected %h, actual %h", want.code, code);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_char: expected %b, actual %b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [UNITS_W-1:0]   cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [CHAR_W-1:0]    m_tdata;
    logic                 m_tlast;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;

    char_scoreboard text_board;

    autoscale_decimal_formatter_unit #(
        .UNITS_MAX_CHARS(UNITS_CLAMP)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The output side owns its stall counter, so a hold-off is counted here
    // while the sender keeps offering readings.
    initial
    begin
        int stall_left;
        int holds_seen;
        stall_left = 0;
        holds_seen = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                text_board.check_char(m_tdata, m_tlast);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic configure(input logic us, input logic [UNITS_W-1:0] text,
                             input logic [ULEN_W-1:0] len);
        cfg_we    <= 1'b1;
        cfg_index <= REG_UNIT_SET;
        cfg_wdata <= {{(UNITS_W-1){1'b0}}, us};
        @(posedge clk);
        cfg_index <= REG_UNITS_TEXT;
        cfg_wdata <= text;
        @(posedge clk);
        cfg_index <= REG_UNITS_LENGTH;
        cfg_wdata <= {{(UNITS_W-ULEN_W){1'b0}}, len};
        @(posedge clk);
        cfg_we <= 1'b0;
        text_board.set_register(REG_UNIT_SET, {{(UNITS_W-1){1'b0}}, us});
        text_board.set_register(REG_UNITS_TEXT, text);
        text_board.set_register(REG_UNITS_LENGTH, {{(UNITS_W-ULEN_W){1'b0}}, len});
    endtask

    task automatic send_reading(input logic [IN_W-1:0] reading);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= reading;
        do
            @(posedge clk);
        while (!s_tready);
        text_board.note_reading(reading);
    endtask

    task automatic drain_text();
        s_tvalid <= 1'b0;
        while (text_board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] random_reading();
        int unsigned pick;
        int unsigned ndig;
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        pick = $urandom_range(19);
        if (pick == 0)
            return '0;
        if (pick < 3)
            return {1'b1, 31'($urandom())};
        if (pick < 5)
            return $urandom();
        ndig = $urandom_range(10, 1);
        lo = 1;
        for (k = 1; k < ndig; k++)
            lo = lo * 10;
        hi = (ndig == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
        pick = $urandom_range(3);
        if (pick == 0)
            return lo;
        if (pick == 1)
            return hi;
        return $urandom_range(hi, lo);
    endfunction

    initial
    begin
        logic [IN_W-1:0]    directed[25];
        logic               set_unit[PHASES];
        logic [UNITS_W-1:0] set_text[PHASES];
        logic [ULEN_W-1:0]  set_len[PHASES];
        logic [UNITS_W-1:0] text;
        int                 phase;
        int                 n;
        directed = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd9,
                     32'd10, 32'd99, 32'd100, 32'd999, 32'd1000, 32'd1234, 32'd9999,
                     32'd10000, 32'd12345, 32'd99999, 32'd100000, 32'd999999,
                     32'd1000000, 32'd1000001, 32'd9999999, 32'd100000000,
                     32'd999999999, 32'd1000000000, 32'hFFFF_FC18};
        set_unit = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        set_text = '{32'h7370_6D41, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0057_0041,
                     32'h0000_0000, 32'h0000_0056};
        set_len  = '{3'd4, 3'd0, 3'd7, 3'd5, 3'd3, 3'd1};

        text_board = new();
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_UNIT_SET;
        cfg_wdata      <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        hold_requests  <= 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults first: milli input and no unit characters.
        for (n = 0; n < 25; n++)
            send_reading(directed[n]);
        drain_text();

        for (phase = 0; phase < PHASES; phase++)
        begin
            text = (phase == 4) ? $urandom() : set_text[phase];
            configure(set_unit[phase], text, set_len[phase]);
            case (phase % 4)
                0:
                begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct  <= 59;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 59;
                    hold_requests  <= hold_requests + 1;
                end
                default:
                begin
                    send_idle_pct  <= 6;
                    recv_stall_pct <= 6;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    drain_text();
                send_reading(random_reading());
            end
            drain_text();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (text_board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
